>>> hw/rtl/csvrp_pkg.sv
package csvrp_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE       = 2'd0;
   localparam logic [1:0] KIND_FIELD_END  = 2'd1;
   localparam logic [1:0] KIND_ROW_END    = 2'd2;
   localparam logic [1:0] KIND_STREAM_END = 2'd3;

   // register indexes on the config port
   localparam logic [1:0] REG_DELIMITER = 2'd0;
   localparam logic [1:0] REG_QUOTE     = 2'd1;
   localparam logic [1:0] REG_TRIM      = 2'd2;
   localparam logic [1:0] REG_BOM       = 2'd3;

   // register reset values
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;
   localparam logic       TRIM_RESET      = 1'b0;
   localparam logic       BOM_RESET       = 1'b1;

   // special bytes
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // last matched position of the byte order mark
   localparam logic [1:0] BOM_LAST_POS = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_REPLAY,
      OP_TAKE,
      OP_CLOSE
   } op_type;

   typedef enum logic [1:0] {
      EM_NONE,
      EM_FLUSH,
      EM_FINAL,
      EM_STREAM
   } emit_type;

   typedef enum logic [1:0] {
      BOM_NONE,
      BOM_ADVANCE,
      BOM_FINISH
   } bom_cmd_type;

   // controller to datapath
   typedef struct packed {
      logic        accept;
      op_type      op;
      logic        rep_sel;
      bom_cmd_type bom;
      emit_type    emit;
      logic        finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       cur_eos;
      logic       bom_done;
      logic       bom_match;
      logic [1:0] bom_pos;
      logic       act_emit;
      logic       has_flush;
      logic       flush_last;
      logic       out_free;
      logic       hold_valid;
   } status_type;

   // utf-8 byte order mark bytes
   function automatic logic [7:0] mark_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = 8'hEF;
         2'd1: b = 8'hBB;
         2'd2: b = 8'hBF;
         2'd3: b = 8'h00;
      endcase
      return b;
   endfunction

   // space, tab, lf, vt, ff, cr
   function automatic logic is_ws(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

endpackage

>>> hw/rtl/csvrp_if.sv
interface csvrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface csvrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       ws_overflow;
   logic       last;

   modport source (output valid, output kind, output out_byte, output ws_overflow,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input ws_overflow,
                   input last, output ready);
endinterface

>>> hw/rtl/csvrp_ctrl.sv
module csvrp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csvrp_pkg::status_type status,
   output csvrp_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_REPLAY,
      S_TAKE,
      S_CLOSE,
      S_FLUSH,
      S_FINAL,
      S_STREAM,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_REPLAY,
      PH_TAKE,
      PH_CLOSE
   } phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in, phase_cur;
   logic       rep_idx_ff, rep_idx_in;
   logic [1:0] rep_n_ff, rep_n_in;
   state_type  adv_state;
   logic       adv_idx;

   assign req_ready = (state_ff == S_IDLE);

   // phase of the op that is running or just ran
   always_comb begin
      unique case (state_ff)
         S_REPLAY: phase_cur = PH_REPLAY;
         S_TAKE:   phase_cur = PH_TAKE;
         S_CLOSE:  phase_cur = PH_CLOSE;
         default:  phase_cur = phase_ff;
      endcase
   end

   // where to go once an op and its results are done
   always_comb begin
      adv_idx = rep_idx_ff;
      unique case (phase_cur)
         PH_REPLAY: begin
            if ((2'({1'b0, rep_idx_ff}) + 2'd1) < rep_n_ff) begin
               adv_state = S_REPLAY;
               adv_idx   = 1'b1;
            end else if (status.cur_eos) begin
               adv_state = S_CLOSE;
            end else begin
               adv_state = S_TAKE;
            end
         end
         PH_TAKE:  adv_state = S_DONE;
         PH_CLOSE: adv_state = S_STREAM;
         default:  adv_state = S_DONE;
      endcase
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      rep_idx_in  = rep_idx_ff;
      rep_n_in    = rep_n_ff;
      cmd         = '0;
      cmd.rep_sel = rep_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rep_idx_in = 1'b0;
            rep_n_in   = status.bom_pos;
            if (status.cur_eos) begin
               if (!status.bom_done && (status.bom_pos != 2'd0)) begin
                  cmd.bom  = csvrp_pkg::BOM_FINISH;
                  state_in = S_REPLAY;
               end else begin
                  state_in = S_CLOSE;
               end
            end else if (status.bom_done) begin
               state_in = S_TAKE;
            end else if (status.bom_match) begin
               cmd.bom  = csvrp_pkg::BOM_ADVANCE;
               state_in = S_DONE;
            end else begin
               cmd.bom  = csvrp_pkg::BOM_FINISH;
               state_in = (status.bom_pos != 2'd0) ? S_REPLAY : S_TAKE;
            end
         end
         S_REPLAY, S_TAKE, S_CLOSE: begin
            priority case (state_ff)
               S_REPLAY: cmd.op = csvrp_pkg::OP_REPLAY;
               S_TAKE:   cmd.op = csvrp_pkg::OP_TAKE;
               default:  cmd.op = csvrp_pkg::OP_CLOSE;
            endcase
            phase_in = phase_cur;
            if (status.act_emit) begin
               state_in = status.has_flush ? S_FLUSH : S_FINAL;
            end else begin
               state_in   = adv_state;
               rep_idx_in = adv_idx;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.emit = csvrp_pkg::EM_FLUSH;
               if (status.flush_last) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.emit   = csvrp_pkg::EM_FINAL;
               state_in   = adv_state;
               rep_idx_in = adv_idx;
            end
         end
         S_STREAM: begin
            if (status.out_free) begin
               cmd.emit = csvrp_pkg::EM_STREAM;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.hold_valid || status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_TAKE;
         rep_idx_ff <= 1'b0;
         rep_n_ff   <= 2'd0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         rep_idx_ff <= rep_idx_in;
         rep_n_ff   <= rep_n_in;
      end
   end

endmodule

>>> hw/rtl/csvrp_datapath.sv
module csvrp_datapath #(
   parameter int MAX_PENDING_WS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  csvrp_pkg::cmd_type    cmd,
   output csvrp_pkg::status_type status,
   input  logic [7:0]            delimiter_char,
   input  logic [7:0]            quote_char,
   input  logic                  trim_enable,
   input  logic                  bom_enable,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_stream,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_ws_overflow,
   output logic                  rsp_last
);

   localparam int CNT_W = $clog2(MAX_PENDING_WS + 1);
   localparam int IDX_W = (MAX_PENDING_WS > 1) ? $clog2(MAX_PENDING_WS) : 1;

   // current item
   logic [7:0] cur_byte_ff;
   logic       cur_eos_ff;

   // parser state
   logic       in_quoted_ff, in_quoted_in;
   logic       quote_pending_ff, quote_pending_in;
   logic       after_cr_ff, after_cr_in;
   logic       row_started_ff, row_started_in;
   logic       field_is_empty_ff, field_is_empty_in;
   logic [1:0] bom_pos_ff, bom_pos_in;
   logic       bom_done_ff, bom_done_in;
   logic       ovf_ff, ovf_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0] ws_store_ff [MAX_PENDING_WS];

   // result of the last op
   logic [1:0]       op_kind_ff;
   logic [7:0]       op_byte_ff;
   logic             op_ovf_ff;
   logic [CNT_W-1:0] flush_n_ff;
   logic [IDX_W-1:0] flush_idx_ff;

   // one result held back until the next one, or the item end, sets last
   logic       hold_valid_ff, hold_valid_in;
   logic [1:0] hold_kind_ff;
   logic [7:0] hold_byte_ff;
   logic       hold_ovf_ff;
   logic [1:0] emit_kind;
   logic [7:0] emit_byte;
   logic       emit_ovf;
   logic       emit_any;
   logic       move;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_ovf_ff;
   logic       rsp_last_ff;

   // op decode
   logic [7:0] op_char;
   logic       dispatch;
   logic       do_push;
   logic [7:0] push_val;
   logic       do_end;
   logic [1:0] end_kind;
   logic       end_drop;
   logic       do_flush;
   logic       act_emit;
   logic       st_we;
   logic [1:0] fin_kind;
   logic [7:0] fin_byte;

   assign op_char = (cmd.op == csvrp_pkg::OP_REPLAY) ?
                    csvrp_pkg::mark_byte({1'b0, cmd.rep_sel}) : cur_byte_ff;

   // parser step: one byte, or the stream close
   always_comb begin
      in_quoted_in      = in_quoted_ff;
      quote_pending_in  = quote_pending_ff;
      after_cr_in       = after_cr_ff;
      row_started_in    = row_started_ff;
      field_is_empty_in = field_is_empty_ff;
      bom_pos_in        = bom_pos_ff;
      bom_done_in       = bom_done_ff;
      ovf_in            = ovf_ff;
      count_in          = count_ff;
      dispatch          = 1'b0;
      do_push           = 1'b0;
      push_val          = op_char;
      do_end            = 1'b0;
      end_kind          = csvrp_pkg::KIND_FIELD_END;
      end_drop          = 1'b0;
      do_flush          = 1'b0;
      act_emit          = 1'b0;
      st_we             = 1'b0;
      fin_kind          = csvrp_pkg::KIND_BYTE;
      fin_byte          = 8'h00;

      unique case (cmd.op)
         csvrp_pkg::OP_NONE: begin
         end
         csvrp_pkg::OP_REPLAY, csvrp_pkg::OP_TAKE: begin
            after_cr_in = 1'b0;
            // lf right after a row-ending cr is swallowed
            if (!(after_cr_ff && (op_char == csvrp_pkg::CHAR_LF))) begin
               row_started_in = 1'b1;
               if (quote_pending_ff) begin
                  quote_pending_in = 1'b0;
                  if (op_char == quote_char) begin
                     do_push  = 1'b1;
                     push_val = quote_char;
                  end else begin
                     in_quoted_in = 1'b0;
                     dispatch     = 1'b1;
                  end
               end else if (in_quoted_ff) begin
                  if (op_char == quote_char) begin
                     quote_pending_in = 1'b1;
                  end else begin
                     do_push = 1'b1;
                  end
               end else begin
                  dispatch = 1'b1;
               end
               // outside quotes: delimiter wins over quote
               if (dispatch) begin
                  if (op_char == delimiter_char) begin
                     do_end   = 1'b1;
                     end_kind = csvrp_pkg::KIND_FIELD_END;
                     end_drop = trim_enable;
                  end else if ((op_char == csvrp_pkg::CHAR_LF) ||
                               (op_char == csvrp_pkg::CHAR_CR)) begin
                     do_end         = 1'b1;
                     end_kind       = csvrp_pkg::KIND_ROW_END;
                     end_drop       = trim_enable;
                     row_started_in = 1'b0;
                     after_cr_in    = (op_char == csvrp_pkg::CHAR_CR);
                  end else if ((op_char == quote_char) && field_is_empty_ff) begin
                     in_quoted_in = 1'b1;
                  end else if (!(trim_enable && field_is_empty_ff &&
                                 csvrp_pkg::is_ws(op_char))) begin
                     do_push = 1'b1;
                  end
               end
            end
         end
         csvrp_pkg::OP_CLOSE: begin
            // a pending quote closes the quoting
            if (quote_pending_ff) begin
               quote_pending_in = 1'b0;
               in_quoted_in     = 1'b0;
            end
            if (row_started_ff) begin
               do_end   = 1'b1;
               end_kind = csvrp_pkg::KIND_ROW_END;
               end_drop = trim_enable && !(in_quoted_ff && !quote_pending_ff);
            end
         end
      endcase

      // field byte: hold whitespace or flush and emit
      if (do_push) begin
         field_is_empty_in = 1'b0;
         if (trim_enable && csvrp_pkg::is_ws(push_val)) begin
            if (count_ff < CNT_W'(MAX_PENDING_WS)) begin
               st_we = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end else begin
            act_emit = 1'b1;
            do_flush = 1'b1;
            fin_kind = csvrp_pkg::KIND_BYTE;
            fin_byte = push_val;
         end
      end

      // field end: drop or flush held whitespace
      if (do_end) begin
         act_emit          = 1'b1;
         fin_kind          = end_kind;
         fin_byte          = 8'h00;
         ovf_in            = 1'b0;
         field_is_empty_in = 1'b1;
         if (end_drop) begin
            count_in = '0;
         end else begin
            do_flush = 1'b1;
         end
      end

      if (do_flush) begin
         count_in = '0;
      end
      if (st_we) begin
         count_in = count_ff + CNT_W'(1);
      end

      // byte order mark tracking
      unique case (cmd.bom)
         csvrp_pkg::BOM_NONE: begin
         end
         csvrp_pkg::BOM_ADVANCE: begin
            if (bom_pos_ff == csvrp_pkg::BOM_LAST_POS) begin
               bom_done_in = 1'b1;
               bom_pos_in  = 2'd0;
            end else begin
               bom_pos_in = bom_pos_ff + 2'd1;
            end
         end
         csvrp_pkg::BOM_FINISH: begin
            bom_done_in = 1'b1;
            bom_pos_in  = 2'd0;
         end
         default: begin
         end
      endcase

      // stream end: back to stream start
      if (cmd.emit == csvrp_pkg::EM_STREAM) begin
         in_quoted_in      = 1'b0;
         quote_pending_in  = 1'b0;
         after_cr_in       = 1'b0;
         row_started_in    = 1'b0;
         field_is_empty_in = 1'b1;
         bom_pos_in        = 2'd0;
         bom_done_in       = 1'b0;
         ovf_in            = 1'b0;
         count_in          = '0;
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_quoted_ff      <= 1'b0;
         quote_pending_ff  <= 1'b0;
         after_cr_ff       <= 1'b0;
         row_started_ff    <= 1'b0;
         field_is_empty_ff <= 1'b1;
         bom_pos_ff        <= 2'd0;
         bom_done_ff       <= 1'b0;
         ovf_ff            <= 1'b0;
         count_ff          <= '0;
         cur_eos_ff        <= 1'b0;
      end else begin
         in_quoted_ff      <= in_quoted_in;
         quote_pending_ff  <= quote_pending_in;
         after_cr_ff       <= after_cr_in;
         row_started_ff    <= row_started_in;
         field_is_empty_ff <= field_is_empty_in;
         bom_pos_ff        <= bom_pos_in;
         bom_done_ff       <= bom_done_in;
         ovf_ff            <= ovf_in;
         count_ff          <= count_in;
         if (cmd.accept) begin
            cur_eos_ff <= end_of_stream;
         end
      end
   end

   // item byte, whitespace store and op result
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_byte_ff <= in_byte;
      end
      if (st_we) begin
         ws_store_ff[count_ff[IDX_W-1:0]] <= push_val;
      end
      if (cmd.op != csvrp_pkg::OP_NONE) begin
         op_kind_ff   <= fin_kind;
         op_byte_ff   <= fin_byte;
         op_ovf_ff    <= ovf_ff;
         flush_n_ff   <= do_flush ? count_ff : '0;
         flush_idx_ff <= '0;
      end else if (cmd.emit == csvrp_pkg::EM_FLUSH) begin
         flush_idx_ff <= flush_idx_ff + IDX_W'(1);
      end
   end

   // result selection
   always_comb begin
      unique case (cmd.emit)
         csvrp_pkg::EM_FLUSH: begin
            emit_kind = csvrp_pkg::KIND_BYTE;
            emit_byte = ws_store_ff[flush_idx_ff];
            emit_ovf  = op_ovf_ff;
         end
         csvrp_pkg::EM_FINAL: begin
            emit_kind = op_kind_ff;
            emit_byte = op_byte_ff;
            emit_ovf  = op_ovf_ff;
         end
         csvrp_pkg::EM_STREAM: begin
            emit_kind = csvrp_pkg::KIND_STREAM_END;
            emit_byte = 8'h00;
            emit_ovf  = 1'b0;
         end
         default: begin
            emit_kind = csvrp_pkg::KIND_BYTE;
            emit_byte = 8'h00;
            emit_ovf  = 1'b0;
         end
      endcase
   end

   assign emit_any = (cmd.emit != csvrp_pkg::EM_NONE);
   assign move     = (emit_any || cmd.finish) && hold_valid_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (emit_any) begin
         hold_valid_in = 1'b1;
      end else if (cmd.finish) begin
         hold_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_any) begin
         hold_kind_ff <= emit_kind;
         hold_byte_ff <= emit_byte;
         hold_ovf_ff  <= emit_ovf;
      end
      if (move) begin
         rsp_kind_ff <= hold_kind_ff;
         rsp_byte_ff <= hold_byte_ff;
         rsp_ovf_ff  <= hold_ovf_ff;
         rsp_last_ff <= cmd.finish;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_ws_overflow = rsp_ovf_ff;
   assign rsp_last        = rsp_last_ff;

   // status back to the controller
   assign status.cur_eos    = cur_eos_ff;
   assign status.bom_done   = bom_done_ff;
   assign status.bom_match  = bom_enable && !bom_done_ff && (bom_pos_ff != 2'd3) &&
                              (cur_byte_ff == csvrp_pkg::mark_byte(bom_pos_ff));
   assign status.bom_pos    = bom_pos_ff;
   assign status.act_emit   = act_emit;
   assign status.has_flush  = do_flush && (count_ff != '0);
   assign status.flush_last = ((CNT_W'(flush_idx_ff) + CNT_W'(1)) == flush_n_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.hold_valid = hold_valid_ff;

endmodule

>>> hw/rtl/csv_row_parser_core.sv
// csv row parser core
// Splits a CSV byte stream into field bytes, field ends, row ends and a
// stream end. req_bus carries one raw byte per beat, or an end-of-stream
// beat; rsp_bus carries one result per beat, with last set on the final
// result caused by each request beat. Delimiter, quote, trimming and
// byte order mark stripping are set through the APB port at byte addresses
// 0, 4, 8 and 12; the user must write them only while the block is idle,
// which the block does not enforce. Requests are handled one at a time:
// the controller decides, replays held byte order mark bytes, takes the
// byte or closes the stream, and walks the results one per cycle while the
// receiver does not stall, through the held-whitespace store and the single
// output register; a matched mark byte goes to the finish. The first result
// shows on rsp_bus once the next one (or the end of the beat) is known.
// Reset returns the registers to their defaults and the parser to stream
// start. When the receiver stalls, the output register holds its beat and
// the controller waits, so req_bus ready stays low until the beat is done.
module csv_row_parser_core #(
   parameter int MAX_PENDING_WS = 16
) (
   input  logic        clock,
   input  logic        reset,
   csvrp_req_if.sink   req_bus,
   csvrp_rsp_if.source rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0] delimiter_char_ff;
   logic [7:0] quote_char_ff;
   logic       trim_enable_ff;
   logic       bom_enable_ff;
   logic       csr_write;
   logic [1:0] csr_index;

   csvrp_pkg::cmd_type    cmd;
   csvrp_pkg::status_type status;

   // config registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_char_ff <= csvrp_pkg::DELIMITER_RESET;
         quote_char_ff     <= csvrp_pkg::QUOTE_RESET;
         trim_enable_ff    <= csvrp_pkg::TRIM_RESET;
         bom_enable_ff     <= csvrp_pkg::BOM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            csvrp_pkg::REG_DELIMITER: delimiter_char_ff <= pwdata[7:0];
            csvrp_pkg::REG_QUOTE:     quote_char_ff     <= pwdata[7:0];
            csvrp_pkg::REG_TRIM:      trim_enable_ff    <= pwdata[0];
            csvrp_pkg::REG_BOM:       bom_enable_ff     <= pwdata[0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         csvrp_pkg::REG_DELIMITER: prdata = {24'h0, delimiter_char_ff};
         csvrp_pkg::REG_QUOTE:     prdata = {24'h0, quote_char_ff};
         csvrp_pkg::REG_TRIM:      prdata = {31'h0, trim_enable_ff};
         csvrp_pkg::REG_BOM:       prdata = {31'h0, bom_enable_ff};
      endcase
   end

   // sequencer
   csvrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parser state, whitespace store and result path
   csvrp_datapath #(
      .MAX_PENDING_WS (MAX_PENDING_WS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .delimiter_char  (delimiter_char_ff),
      .quote_char      (quote_char_ff),
      .trim_enable     (trim_enable_ff),
      .bom_enable      (bom_enable_ff),
      .in_byte         (req_bus.in_byte),
      .end_of_stream   (req_bus.end_of_stream),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_kind        (rsp_bus.kind),
      .rsp_out_byte    (rsp_bus.out_byte),
      .rsp_ws_overflow (rsp_bus.ws_overflow),
      .rsp_last        (rsp_bus.last)
   );

   // a new request beat never finds a result still held back
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> !status.hold_valid)
      else $error("request accepted while a result is still held");

   // stream end is always the final result of its beat
   a_stream_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.kind == csvrp_pkg::KIND_STREAM_END)) |-> rsp_bus.last)
      else $error("stream end without last");

   // only field bytes carry a byte value
   a_mark_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.kind != csvrp_pkg::KIND_BYTE)) |-> (rsp_bus.out_byte == 8'h00))
      else $error("mark result carries a nonzero byte");

   // the stream end result carries no overflow
   a_stream_end_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.kind == csvrp_pkg::KIND_STREAM_END)) |-> !rsp_bus.ws_overflow)
      else $error("stream end with overflow flag");

endmodule
